>>> hw/rtl/lidar_point_to_pixel_and_polar_bin_assert.svh
// Assertion macros for the lidar point to pixel and polar bin block.
// Users must have clk_i and rst_ni in scope; the reset disables every check.
`ifndef LIDAR_POINT_TO_PIXEL_AND_POLAR_BIN_ASSERT_SVH
`define LIDAR_POINT_TO_PIXEL_AND_POLAR_BIN_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/lpp_pkg.sv
// Shared types, widths and constants of the lidar point to pixel and polar bin block.
// Used by the channel interfaces, the arithmetic units, the top level and the checker.
`default_nettype none

package lpp_pkg;

  localparam int unsigned IN_W   = 16;
  localparam int unsigned PIX_W  = 10;
  localparam int unsigned ANG_W  = 8;
  localparam int unsigned DIST_W = 16;
  localparam int unsigned SQ_W   = 32;
  localparam int unsigned CFG_W  = 10;

  localparam logic [CFG_W-1:0] IMAGE_SIZE_RST = 10'd1000;
  localparam logic [7:0]       PIX_SCALE      = 8'd250;

  localparam int unsigned CORDIC_STEPS    = 40;
  localparam int unsigned CORDIC_PRESHIFT = 30;
  localparam int unsigned CW              = 48;
  localparam int unsigned ZW              = 49;
  localparam int unsigned RW              = 48;
  localparam int unsigned DEG_BITS        = 8;
  localparam int unsigned CORDIC_LAT      = CORDIC_STEPS + DEG_BITS;
  localparam int unsigned SQRT_STEPS      = DIST_W;
  localparam int unsigned PIPE_DEPTH      = CORDIC_LAT + 2;

  localparam logic [RW-1:0]        DEG_UNIT  = 48'd1000000000000;
  localparam logic signed [ZW-1:0] Z_QUARTER = 49'sd90000000000000;

  localparam logic [ANG_W-1:0] DEG_0   = 8'd0;
  localparam logic [ANG_W-1:0] DEG_45  = 8'd45;
  localparam logic [ANG_W-1:0] DEG_90  = 8'd90;
  localparam logic [ANG_W-1:0] DEG_135 = 8'd135;
  localparam logic [ANG_W-1:0] DEG_180 = 8'd180;

  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic             bin_hit;
    logic             use_fixed;
    logic [ANG_W-1:0] fixed_deg;
  } angle_ctl_t;

  // Rotation angle of step i, in units of 1e-12 degree.
  function automatic logic signed [ZW-1:0] atan_step(input int unsigned i);
    logic signed [ZW-1:0] r;
    unique case (i)
      0:  r = 49'sd45000000000000;
      1:  r = 49'sd26565051177078;
      2:  r = 49'sd14036243467926;
      3:  r = 49'sd7125016348902;
      4:  r = 49'sd3576334374997;
      5:  r = 49'sd1789910608246;
      6:  r = 49'sd895173710211;
      7:  r = 49'sd447614170861;
      8:  r = 49'sd223810500369;
      9:  r = 49'sd111905677066;
      10: r = 49'sd55952891894;
      11: r = 49'sd27976452617;
      12: r = 49'sd13988227142;
      13: r = 49'sd6994113675;
      14: r = 49'sd3497056851;
      15: r = 49'sd1748528427;
      16: r = 49'sd874264214;
      17: r = 49'sd437132107;
      18: r = 49'sd218566053;
      19: r = 49'sd109283027;
      20: r = 49'sd54641513;
      21: r = 49'sd27320757;
      22: r = 49'sd13660378;
      23: r = 49'sd6830189;
      24: r = 49'sd3415095;
      25: r = 49'sd1707547;
      26: r = 49'sd853774;
      27: r = 49'sd426887;
      28: r = 49'sd213443;
      29: r = 49'sd106722;
      30: r = 49'sd53361;
      31: r = 49'sd26680;
      32: r = 49'sd13340;
      33: r = 49'sd6670;
      34: r = 49'sd3335;
      35: r = 49'sd1668;
      36: r = 49'sd834;
      37: r = 49'sd417;
      38: r = 49'sd208;
      39: r = 49'sd104;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lpp_if.sv
// Valid/ready channel interfaces for lidar points and pixel/bin results.
// Depends on lpp_pkg for the field widths.
`default_nettype none

interface lpp_point_if;
  import lpp_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] point_x;
  logic signed [IN_W-1:0] point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink (input valid, input point_x, input point_y, output ready);
endinterface

interface lpp_result_if;
  import lpp_pkg::*;

  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  pixel_col;
  logic [PIX_W-1:0]  pixel_row;
  logic              pixel_hit;
  logic [ANG_W-1:0]  angle_bin;
  logic [DIST_W-1:0] bin_distance;
  logic              bin_hit;

  modport source (
    output valid, output pixel_col, output pixel_row, output pixel_hit,
    output angle_bin, output bin_distance, output bin_hit, input ready
  );
  modport sink (
    input valid, input pixel_col, input pixel_row, input pixel_hit,
    input angle_bin, input bin_distance, input bin_hit, output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/lpp_cordic.sv
// Pipelined vectoring CORDIC giving atan2 in 1e-12 degree, then a restoring
// divider that truncates it to whole degrees. Depends on lpp_pkg.
`default_nettype none

module lpp_cordic (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [lpp_pkg::IN_W-1:0]  x_i,
  input  logic signed [lpp_pkg::IN_W-1:0]  y_i,
  output logic        [lpp_pkg::ANG_W-1:0] deg_o
);
  import lpp_pkg::*;

  logic signed [CW-1:0] xs_q [CORDIC_STEPS];
  logic signed [CW-1:0] ys_q [CORDIC_STEPS];
  logic signed [ZW-1:0] z_q  [CORDIC_STEPS];
  logic signed [CW-1:0] x_ext, y_ext;
  logic signed [CW-1:0] xs0, ys0;
  logic signed [ZW-1:0] z0;

  logic [RW-1:0]    r_q [DEG_BITS-1];
  logic [ANG_W-1:0] q_q [DEG_BITS];

  assign x_ext = {{(CW-IN_W){x_i[IN_W-1]}}, x_i};
  assign y_ext = {{(CW-IN_W){y_i[IN_W-1]}}, y_i};

  // Points behind the sensor are first turned by a quarter circle.
  always_comb begin
    if (x_i[IN_W-1]) begin
      xs0 = y_ext <<< CORDIC_PRESHIFT;
      ys0 = (-x_ext) <<< CORDIC_PRESHIFT;
      z0  = Z_QUARTER;
    end else begin
      xs0 = x_ext <<< CORDIC_PRESHIFT;
      ys0 = y_ext <<< CORDIC_PRESHIFT;
      z0  = '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [ZW-1:0] ANG = atan_step(i);
    logic signed [CW-1:0] xin, yin, dx, dy;
    logic signed [ZW-1:0] zin;

    if (i == 0) begin : g_first
      assign xin = xs0;
      assign yin = ys0;
      assign zin = z0;
    end else begin : g_next
      assign xin = xs_q[i-1];
      assign yin = ys_q[i-1];
      assign zin = z_q[i-1];
    end

    assign dx = yin >>> i;
    assign dy = xin >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (yin > 0) begin
          xs_q[i] <= xin + dx;
          ys_q[i] <= yin - dy;
          z_q[i]  <= zin + ANG;
        end else begin
          xs_q[i] <= xin - dx;
          ys_q[i] <= yin + dy;
          z_q[i]  <= zin - ANG;
        end
      end
    end
  end

  for (genvar k = 0; k < DEG_BITS; k++) begin : g_deg
    localparam int unsigned  B   = DEG_BITS - 1 - k;
    localparam logic [RW-1:0] DVS = RW'(DEG_UNIT << B);
    logic [RW-1:0]    rin, r_d;
    logic [ANG_W-1:0] qin, q_d;

    if (k == 0) begin : g_first
      assign rin = z_q[CORDIC_STEPS-1][ZW-1] ? '0 : z_q[CORDIC_STEPS-1][RW-1:0];
      assign qin = '0;
    end else begin : g_next
      assign rin = r_q[k-1];
      assign qin = q_q[k-1];
    end

    always_comb begin
      r_d = rin;
      q_d = qin;
      if (rin >= DVS) begin
        r_d    = rin - DVS;
        q_d[B] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[k] <= q_d;
      end
    end

    if (k < DEG_BITS - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[k] <= r_d;
        end
      end
    end
  end

  assign deg_o = q_q[DEG_BITS-1];

endmodule

`default_nettype wire

>>> hw/rtl/lpp_isqrt.sv
// Pipelined integer square root, one result bit per stage, floor rounding.
// Depends on lpp_pkg for the operand and root widths.
`default_nettype none

module lpp_isqrt (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [lpp_pkg::SQ_W-1:0]          n_i,
  output logic [lpp_pkg::DIST_W-1:0]        root_o
);
  import lpp_pkg::*;

  logic [SQ_W-1:0] n_q   [SQRT_STEPS-1];
  logic [SQ_W-1:0] res_q [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * j);
    logic [SQ_W-1:0] nin, rin, n_d, res_d;
    logic [SQ_W:0]   trial;

    if (j == 0) begin : g_first
      assign nin = n_i;
      assign rin = '0;
    end else begin : g_next
      assign nin = n_q[j-1];
      assign rin = res_q[j-1];
    end

    assign trial = {1'b0, rin} + {1'b0, BIT};

    always_comb begin
      if ({1'b0, nin} >= trial) begin
        n_d   = nin - trial[SQ_W-1:0];
        res_d = (rin >> 1) + BIT;
      end else begin
        n_d   = nin;
        res_d = rin >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        res_q[j] <= res_d;
      end
    end

    if (j < SQRT_STEPS - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          n_q[j] <= n_d;
        end
      end
    end
  end

  assign root_o = res_q[SQRT_STEPS-1][DIST_W-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/lidar_point_to_pixel_and_polar_bin.sv
// Top level: maps a lidar point to a top-down pixel and a polar bin write.
// Depends on lpp_pkg, lpp_if, lpp_cordic and lpp_isqrt.
//
//   channel    direction  contents
//   point_i    in         point_x, point_y
//   result_o   out        pixel_col, pixel_row, pixel_hit, angle_bin, bin_distance, bin_hit
//   cfg        in         cfg_we_i, cfg_idx_i, cfg_data_i (image width, image height)
//
// One point is accepted per cycle while the output buffer is not full.
// The pipeline depth is set by the 40-step CORDIC and its 8-step degree divider.
// After reset both image sizes are 1000 and the pipeline is empty; there is no clearing pass.
// A two-entry output buffer decouples the sides: the pipeline and point_i.ready
// stop only once a result waits in both entries, and nothing is lost or repeated.
`default_nettype none

module lidar_point_to_pixel_and_polar_bin #(
  parameter int unsigned COORD_FRAC_BITS = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  lpp_point_if.sink                  point_i,
  lpp_result_if.source               result_o,
  input  logic                       cfg_we_i,
  input  lpp_pkg::cfg_reg_e          cfg_idx_i,
  input  logic [lpp_pkg::CFG_W-1:0]  cfg_data_i
);
  import lpp_pkg::*;

  localparam int unsigned PW = ((COORD_FRAC_BITS + 2 > IN_W - 1) ?
                                COORD_FRAC_BITS + 2 : IN_W - 1) + 1;
  localparam int unsigned VW     = PW + 1;
  localparam int unsigned PROD_W = PW + 8;
  localparam int unsigned MW     = PROD_W - COORD_FRAC_BITS;
  localparam logic signed [VW-1:0] PIX_ORIGIN = VW'(2) << COORD_FRAC_BITS;

  localparam int unsigned CTL_DLY  = PIPE_DEPTH - 1;
  localparam int unsigned PIX_DLY  = PIPE_DEPTH - 3;
  localparam int unsigned DIST_DLY = PIPE_DEPTH - 3 - SQRT_STEPS;

  typedef struct packed {
    logic [PIX_W-1:0] col;
    logic [PIX_W-1:0] row;
    logic             hit;
  } pix_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel_col;
    logic [PIX_W-1:0]  pixel_row;
    logic              pixel_hit;
    logic [ANG_W-1:0]  angle_bin;
    logic [DIST_W-1:0] bin_distance;
    logic              bin_hit;
  } res_t;

  logic [CFG_W-1:0] width_q, height_q;
  logic             pipe_en;
  logic [PIPE_DEPTH-1:0] vld_q;

  logic signed [IN_W-1:0] x1_q, y1_q;
  logic [SQ_W-1:0]        xx1_q, yy1_q, sq2_q;
  angle_ctl_t             ctl_d;
  angle_ctl_t             ctl_q [CTL_DLY];
  logic [IN_W:0]          xy_sum;

  logic [PIX_W-1:0] ax_val [2];
  logic             ax_hit [2];
  pix_t             pix_d;
  pix_t             pix_q [PIX_DLY];

  logic [DIST_W-1:0] root;
  logic [DIST_W-1:0] dist_q [DIST_DLY];
  logic [ANG_W-1:0]  cordic_deg;

  res_t tail_d, tail_q, out_q, skid_q;
  logic out_vq, skid_vq, push, pop;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= IMAGE_SIZE_RST;
      height_q <= IMAGE_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default:          width_q  <= width_q;
      endcase
    end
  end

  assign pipe_en       = !skid_vq;
  assign point_i.ready = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], point_i.valid};
    end
  end

  // Bearings that are exact multiples of 45 degrees, and points with negative y (no bin write), bypass the CORDIC.
  assign xy_sum = {point_i.point_x[IN_W-1], point_i.point_x} +
                  {point_i.point_y[IN_W-1], point_i.point_y};

  always_comb begin
    ctl_d.bin_hit   = !point_i.point_y[IN_W-1];
    ctl_d.use_fixed = 1'b1;
    ctl_d.fixed_deg = DEG_0;
    priority if (point_i.point_y[IN_W-1]) begin
      ctl_d.fixed_deg = DEG_0;
    end else if (point_i.point_y == '0) begin
      ctl_d.fixed_deg = point_i.point_x[IN_W-1] ? DEG_180 : DEG_0;
    end else if (point_i.point_x == '0) begin
      ctl_d.fixed_deg = DEG_90;
    end else if (point_i.point_x == point_i.point_y) begin
      ctl_d.fixed_deg = DEG_45;
    end else if (xy_sum == '0) begin
      ctl_d.fixed_deg = DEG_135;
    end else begin
      ctl_d.use_fixed = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      x1_q     <= point_i.point_x;
      y1_q     <= point_i.point_y;
      xx1_q    <= SQ_W'(point_i.point_x * point_i.point_x);
      yy1_q    <= SQ_W'(point_i.point_y * point_i.point_y);
      sq2_q    <= xx1_q + yy1_q;
      ctl_q[0] <= ctl_d;
      for (int k = 1; k < CTL_DLY; k++) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end
  end

  // Lane 0 gives the column from y, lane 1 the row from x.
  for (genvar a = 0; a < 2; a++) begin : g_axis
    logic signed [IN_W-1:0] coord;
    logic [CFG_W-1:0]       limit;
    logic signed [VW-1:0]   v;
    logic [PW-1:0]          mag_d, mag_q;
    logic                   neg_q, neg2_q;
    logic [PROD_W-1:0]      prod_q;
    logic [MW-1:0]          m;

    assign coord = (a == 0) ? point_i.point_y : point_i.point_x;
    assign limit = (a == 0) ? width_q : height_q;
    assign v     = PIX_ORIGIN - {{(VW-IN_W){coord[IN_W-1]}}, coord};
    assign mag_d = v[VW-1] ? PW'(-v) : PW'(v);

    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        mag_q  <= mag_d;
        neg_q  <= v[VW-1];
        prod_q <= mag_q * PIX_SCALE;
        neg2_q <= neg_q;
      end
    end

    assign m         = prod_q[PROD_W-1:COORD_FRAC_BITS];
    assign ax_val[a] = m[PIX_W-1:0];
    assign ax_hit[a] = (!neg2_q || m == '0) && (m < MW'(limit));
  end

  always_comb begin
    pix_d.hit = ax_hit[0] && ax_hit[1];
    pix_d.col = pix_d.hit ? ax_val[0] : '0;
    pix_d.row = pix_d.hit ? ax_val[1] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      pix_q[0] <= pix_d;
      for (int k = 1; k < PIX_DLY; k++) begin
        pix_q[k] <= pix_q[k-1];
      end
    end
  end

  lpp_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .n_i    (sq2_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dist_q[0] <= root;
      for (int k = 1; k < DIST_DLY; k++) begin
        dist_q[k] <= dist_q[k-1];
      end
    end
  end

  lpp_cordic u_cordic (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .x_i   (x1_q),
    .y_i   (y1_q),
    .deg_o (cordic_deg)
  );

  always_comb begin
    tail_d.pixel_col    = pix_q[PIX_DLY-1].col;
    tail_d.pixel_row    = pix_q[PIX_DLY-1].row;
    tail_d.pixel_hit    = pix_q[PIX_DLY-1].hit;
    tail_d.bin_distance = dist_q[DIST_DLY-1];
    tail_d.bin_hit      = ctl_q[CTL_DLY-1].bin_hit;
    priority if (ctl_q[CTL_DLY-1].use_fixed) begin
      tail_d.angle_bin = ctl_q[CTL_DLY-1].fixed_deg;
    end else if (cordic_deg > DEG_180) begin
      tail_d.angle_bin = DEG_180;
    end else begin
      tail_d.angle_bin = cordic_deg;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      tail_q <= tail_d;
    end
  end

  // Two-entry output buffer.
  assign push = pipe_en && vld_q[PIPE_DEPTH-1];
  assign pop  = out_vq && result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq  <= 1'b0;
      skid_vq <= 1'b0;
    end else if (skid_vq) begin
      if (pop) begin
        skid_vq <= 1'b0;
      end
    end else if (!out_vq || pop) begin
      out_vq <= push;
    end else if (push) begin
      skid_vq <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vq) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (!out_vq || pop) begin
      if (push) begin
        out_q <= tail_q;
      end
    end else if (push) begin
      skid_q <= tail_q;
    end
  end

  assign result_o.valid        = out_vq;
  assign result_o.pixel_col    = out_q.pixel_col;
  assign result_o.pixel_row    = out_q.pixel_row;
  assign result_o.pixel_hit    = out_q.pixel_hit;
  assign result_o.angle_bin    = out_q.angle_bin;
  assign result_o.bin_distance = out_q.bin_distance;
  assign result_o.bin_hit      = out_q.bin_hit;

endmodule

`default_nettype wire

>>> hw/rtl/lpp_checker.sv
// Port-level checks of the lidar point to pixel and polar bin block, bound to its top level.
// Depends on lpp_pkg and lidar_point_to_pixel_and_polar_bin_assert.svh.
`default_nettype none

`include "lidar_point_to_pixel_and_polar_bin_assert.svh"

module lpp_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic [lpp_pkg::PIX_W-1:0]         pixel_col_i,
  input logic [lpp_pkg::PIX_W-1:0]         pixel_row_i,
  input logic                              pixel_hit_i,
  input logic [lpp_pkg::ANG_W-1:0]         angle_bin_i,
  input logic [lpp_pkg::DIST_W-1:0]        bin_distance_i,
  input logic                              bin_hit_i
);
  import lpp_pkg::*;

  `LPP_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result transaction dropped while stalled")
  `LPP_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, ($stable({pixel_col_i, pixel_row_i, pixel_hit_i, angle_bin_i, bin_distance_i, bin_hit_i})), "result payload changed while stalled")
  `LPP_ASSERT_SAME(a_in_backpressure, !in_ready_i, $past(out_valid_i && !out_ready_i), "point channel stalled without a result stall")
  `LPP_ASSERT_SAME(a_pixel_miss, out_valid_i && !pixel_hit_i, pixel_col_i == '0 && pixel_row_i == '0, "pixel fields not cleared on a miss")
  `LPP_ASSERT_SAME(a_angle_range, out_valid_i, (bin_hit_i || angle_bin_i == DEG_0) && angle_bin_i <= DEG_180, "angle out of range or set without a bin write")

endmodule

bind lidar_point_to_pixel_and_polar_bin lpp_checker u_lpp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (point_i.ready),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .pixel_col_i    (result_o.pixel_col),
  .pixel_row_i    (result_o.pixel_row),
  .pixel_hit_i    (result_o.pixel_hit),
  .angle_bin_i    (result_o.angle_bin),
  .bin_distance_i (result_o.bin_distance),
  .bin_hit_i      (result_o.bin_hit)
);

`default_nettype wire
